// ===== design/lac_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lac_pkg
// Shared types and constants for the lead angle calculator pipeline.
// ----------------------------------------------------------------------------
package lac_pkg;

  localparam int unsigned CORDIC_STEPS = 22;
  localparam int unsigned ANG_W        = 25;   // Q16 degrees, signed
  localparam int unsigned RATIO_W      = 48;   // Q30 drop ratio
  localparam int unsigned CX_W         = 50;   // CORDIC x / y magnitude
  localparam logic [19:0] G_Q16        = 20'd642689;

  localparam logic [1:0] ST_OFF  = 2'd0;
  localparam logic [1:0] ST_ON   = 2'd1;
  localparam logic [1:0] ST_LAG  = 2'd2;
  localparam logic [1:0] ST_ZOOM = 2'd3;

  // sideband through the flight time divider
  typedef struct packed {
    logic               off;
    logic               ovf;
    logic [15:0]        guess;
    logic [19:0]        range;
    logic signed [16:0] az;
    logic signed [16:0] el;
    logic [15:0]        view;
  } tag1_t;

  // sideband through the drop ratio divider
  typedef struct packed {
    logic               off;
    logic signed [23:0] laz;
    logic signed [23:0] lel;
    logic [15:0]        view;
  } tag2_t;

  // sideband through the CORDIC
  typedef struct packed {
    logic  zero;
    tag2_t t2;
  } tag3_t;

  function automatic logic signed [ANG_W-1:0] atan_tab(input int unsigned i);
    logic [ANG_W-1:0] v;
    case (i)
      0:  v = 25'd2949120;
      1:  v = 25'd1740967;
      2:  v = 25'd919879;
      3:  v = 25'd466945;
      4:  v = 25'd234379;
      5:  v = 25'd117304;
      6:  v = 25'd58666;
      7:  v = 25'd29335;
      8:  v = 25'd14668;
      9:  v = 25'd7334;
      10: v = 25'd3667;
      11: v = 25'd1833;
      12: v = 25'd917;
      13: v = 25'd458;
      14: v = 25'd229;
      15: v = 25'd115;
      16: v = 25'd57;
      17: v = 25'd29;
      18: v = 25'd14;
      19: v = 25'd7;
      20: v = 25'd4;
      21: v = 25'd2;
      default: v = '0;
    endcase
    return $signed(v);
  endfunction

  // rate * t / 1024, rounded half away from zero
  function automatic logic signed [23:0] rnd_lead(input logic signed [33:0] p);
    logic [33:0] mag;
    logic [33:0] r;
    mag = p[33] ? 34'(-p) : 34'(p);
    r   = (mag + 34'd512) >> 10;
    return p[33] ? -$signed(r[23:0]) : $signed(r[23:0]);
  endfunction

endpackage
`default_nettype wire

// ===== design/lead_angle_calculator_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lead_angle_calculator_unit
// Ballistic lead angle (azimuth and elevation with gravity drop) per update.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one tracker update per
//   transaction; output channel out_valid/out_ready returns one result
//   (lead_az, lead_el, lead_status) per update, in order.
//   cfg_we/cfg_wdata writes max_lead_angle; write only while idle.
// Pipeline: input register, 16-stage flight time divider, two multiply
//   stages, 48-stage drop ratio divider, 22-stage CORDIC and output
//   register; both dividers are bit-serial pipelines.
// Throughput: one transaction per cycle when the receiver keeps out_ready high.
// Stall: the whole pipeline freezes while a result waits with out_ready low;
//   in_ready drops at the same time, nothing is lost or repeated.
// Reset: synchronous rst_n clears all valid bits and loads max_lead_angle
//   with 2560 (10 degrees).
// ----------------------------------------------------------------------------
module lead_angle_calculator_unit #(
  parameter logic [15:0] MAX_LEAD_RESET = 16'd2560
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [19:0]        in_range_sixteenths,
  input  wire logic signed [16:0] in_az_rate,
  input  wire logic signed [16:0] in_el_rate,
  input  wire logic [14:0]        in_muzzle_speed,
  input  wire logic [15:0]        in_flight_time_guess,
  input  wire logic [15:0]        in_view_width,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [16:0]      out_lead_az,
  output logic signed [16:0]      out_lead_el,
  output logic [1:0]              out_lead_status,
  input  wire logic               cfg_we,
  input  wire logic [15:0]        cfg_wdata
);

  localparam int unsigned T1W = $bits(lac_pkg::tag1_t);
  localparam int unsigned T3W = $bits(lac_pkg::tag3_t);

  logic        en;
  logic [15:0] max_r;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= MAX_LEAD_RESET;
    end else if (cfg_we) begin
      max_r <= cfg_wdata;
    end
  end

  // ---------------- input register
  logic               a_v_r;
  logic [19:0]        a_range_r;
  logic signed [16:0] a_az_r, a_el_r;
  logic [14:0]        a_speed_r;
  logic [15:0]        a_guess_r, a_view_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
    end
    if (en) begin
      a_range_r <= in_range_sixteenths;
      a_az_r    <= in_az_rate;
      a_el_r    <= in_el_rate;
      a_speed_r <= in_muzzle_speed;
      a_guess_r <= in_flight_time_guess;
      a_view_r  <= in_view_width;
    end
  end

  logic [31:0]    num1, num1_in;
  logic [15:0]    den1;
  lac_pkg::tag1_t tag1_in, tag1_out;
  logic           d1_v;
  logic [15:0]    q1;

  always_comb begin
    num1            = {a_range_r, 11'b0} + 32'(a_speed_r);
    den1            = (a_speed_r == '0) ? 16'd1 : {a_speed_r, 1'b0};
    tag1_in.off     = (a_range_r <= 20'd1) ||
                      (a_guess_r == '0 && a_speed_r == '0);
    tag1_in.ovf     = num1 >= {den1, 16'b0};
    tag1_in.guess   = a_guess_r;
    tag1_in.range   = a_range_r;
    tag1_in.az      = a_az_r;
    tag1_in.el      = a_el_r;
    tag1_in.view    = a_view_r;
    num1_in         = (tag1_in.ovf || tag1_in.off || a_guess_r != '0) ? '0 : num1;
  end

  lac_div #(.NW(32), .DW(16), .QW(16), .TW(T1W)) u_div_t (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .v_in    (a_v_r),
    .num     (num1_in),
    .den     (den1),
    .tag_in  (tag1_in),
    .v_out   (d1_v),
    .quo     (q1),
    .tag_out (tag1_out)
  );

  // ---------------- flight time and products
  logic [15:0] t_b;
  always_comb begin
    if (tag1_out.guess != '0)   t_b = tag1_out.guess;
    else if (tag1_out.ovf)      t_b = 16'hFFFF;
    else if (q1 == '0)          t_b = 16'd1;
    else                        t_b = q1;
  end

  logic               m1_v_r, m1_off_r;
  logic [31:0]        m1_tt_r;
  logic signed [33:0] m1_paz_r, m1_pel_r;
  logic [19:0]        m1_range_r;
  logic [15:0]        m1_view_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
    end else if (en) begin
      m1_v_r <= d1_v;
    end
    if (en) begin
      m1_off_r   <= tag1_out.off;
      m1_tt_r    <= 32'(t_b) * 32'(t_b);
      m1_paz_r   <= 34'(tag1_out.az) * $signed({18'b0, t_b});
      m1_pel_r   <= 34'(tag1_out.el) * $signed({18'b0, t_b});
      m1_range_r <= tag1_out.range;
      m1_view_r  <= tag1_out.view;
    end
  end

  logic               m2_v_r, m2_off_r;
  logic [51:0]        m2_gt_r;
  logic signed [23:0] m2_laz_r, m2_lel_r;
  logic [19:0]        m2_range_r;
  logic [15:0]        m2_view_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_v_r <= 1'b0;
    end else if (en) begin
      m2_v_r <= m1_v_r;
    end
    if (en) begin
      m2_off_r   <= m1_off_r;
      m2_gt_r    <= 52'(lac_pkg::G_Q16) * 52'(m1_tt_r);
      m2_laz_r   <= lac_pkg::rnd_lead(m1_paz_r);
      m2_lel_r   <= lac_pkg::rnd_lead(m1_pel_r);
      m2_range_r <= m1_range_r;
      m2_view_r  <= m1_view_r;
    end
  end

  // ---------------- drop ratio divider
  lac_pkg::tag2_t tag2_in, tag2_out;
  logic           d2_v;
  logic [47:0]    q2;

  always_comb begin
    tag2_in.off  = m2_off_r;
    tag2_in.laz  = m2_laz_r;
    tag2_in.lel  = m2_lel_r;
    tag2_in.view = m2_view_r;
  end

  lac_div #(.NW(52), .DW(23), .QW(lac_pkg::RATIO_W), .TW($bits(lac_pkg::tag2_t))) u_div_r (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .v_in    (m2_v_r),
    .num     (m2_off_r ? 52'd0 : m2_gt_r),
    .den     ({m2_range_r, 3'b0}),
    .tag_in  (tag2_in),
    .v_out   (d2_v),
    .quo     (q2),
    .tag_out (tag2_out)
  );

  // ---------------- arctangent
  lac_pkg::tag3_t                    tag3_in, tag3_out;
  logic                              c_v;
  logic signed [lac_pkg::ANG_W-1:0]  ang;

  always_comb begin
    tag3_in.zero = (q2 == '0);
    tag3_in.t2   = tag2_out;
  end

  lac_cordic #(.TW(T3W)) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .v_in    (d2_v),
    .ratio   (q2),
    .tag_in  (tag3_in),
    .v_out   (c_v),
    .ang     (ang),
    .tag_out (tag3_out)
  );

  // ---------------- saturation and status
  logic [lac_pkg::ANG_W-1:0] ang_rnd;
  logic signed [24:0]        lel_t, laz_t, maxs;
  logic signed [16:0]        laz_o, lel_o;
  logic [24:0]               maz, mel;
  logic                      lag;
  logic [1:0]                st;

  always_comb begin
    ang_rnd = (tag3_out.zero || ang < 0) ? '0 : (ang + 25'sd128) >>> 8;
    laz_t   = 25'(tag3_out.t2.laz);
    lel_t   = 25'(tag3_out.t2.lel) + $signed(ang_rnd);
    maxs    = $signed({9'b0, max_r});
    lag     = 1'b0;
    if (laz_t > maxs) begin
      laz_o = 17'(maxs); lag = 1'b1;
    end else if (laz_t < -maxs) begin
      laz_o = 17'(-maxs); lag = 1'b1;
    end else begin
      laz_o = 17'(laz_t);
    end
    if (lel_t > maxs) begin
      lel_o = 17'(maxs); lag = 1'b1;
    end else if (lel_t < -maxs) begin
      lel_o = 17'(-maxs); lag = 1'b1;
    end else begin
      lel_o = 17'(lel_t);
    end
    maz = laz_o[16] ? 25'(-25'(laz_o)) : 25'(laz_o);
    mel = lel_o[16] ? 25'(-25'(lel_o)) : 25'(lel_o);
    if (lag) begin
      st = lac_pkg::ST_LAG;
    end else if (tag3_out.t2.view != '0 &&
                 ((maz << 1) > 25'(tag3_out.t2.view) ||
                  (mel << 1) > 25'(tag3_out.t2.view))) begin
      st = lac_pkg::ST_ZOOM;
    end else begin
      st = lac_pkg::ST_ON;
    end
    if (tag3_out.t2.off) begin
      laz_o = '0;
      lel_o = '0;
      st    = lac_pkg::ST_OFF;
    end
  end

  logic               o_v_r;
  logic signed [16:0] o_az_r, o_el_r;
  logic [1:0]         o_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (en) begin
      o_v_r <= c_v;
    end
    if (en) begin
      o_az_r <= laz_o;
      o_el_r <= lel_o;
      o_st_r <= st;
    end
  end

  assign out_valid       = o_v_r;
  assign out_lead_az     = o_az_r;
  assign out_lead_el     = o_el_r;
  assign out_lead_status = o_st_r;

endmodule
`default_nettype wire

// ===== design/lac_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lac_div
// Pipelined restoring divider, one quotient bit per stage, MSB first.
// Caller guarantees num < den << QW.
// ----------------------------------------------------------------------------
module lac_div #(
  parameter int unsigned NW = 32,
  parameter int unsigned DW = 16,
  parameter int unsigned QW = 16,
  parameter int unsigned TW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          v_in,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  input  wire logic [TW-1:0] tag_in,
  output logic               v_out,
  output logic [QW-1:0]      quo,
  output logic [TW-1:0]      tag_out
);

  localparam int unsigned W = (NW > DW + QW) ? NW : DW + QW;

  logic [W-1:0]  rem_r [QW];
  logic [QW-1:0] q_r   [QW];
  logic [DW-1:0] den_r [QW];
  logic [TW-1:0] tag_r [QW];
  logic [QW-1:0] v_r;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int unsigned B = QW - 1 - k;
    logic [W-1:0]  rem_s;
    logic [QW-1:0] q_s;
    logic [DW-1:0] den_s;
    logic [TW-1:0] tag_s;
    logic          v_s;
    logic [W-1:0]  dsh;
    logic [W-1:0]  rem_nxt;
    logic [QW-1:0] q_nxt;

    if (k == 0) begin : g_first
      assign rem_s = W'(num);
      assign q_s   = '0;
      assign den_s = den;
      assign tag_s = tag_in;
      assign v_s   = v_in;
    end else begin : g_rest
      assign rem_s = rem_r[k-1];
      assign q_s   = q_r[k-1];
      assign den_s = den_r[k-1];
      assign tag_s = tag_r[k-1];
      assign v_s   = v_r[k-1];
    end

    always_comb begin
      dsh     = W'(den_s) << B;
      rem_nxt = rem_s;
      q_nxt   = q_s;
      if (rem_s >= dsh) begin
        rem_nxt  = rem_s - dsh;
        q_nxt[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_s;
      end
      if (en) begin
        rem_r[k] <= rem_nxt;
        q_r[k]   <= q_nxt;
        den_r[k] <= den_s;
        tag_r[k] <= tag_s;
      end
    end
  end

  assign v_out   = v_r[QW-1];
  assign quo     = q_r[QW-1];
  assign tag_out = tag_r[QW-1];

endmodule
`default_nettype wire

// ===== design/lac_cordic.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lac_cordic
// Pipelined unsigned CORDIC vectoring, one rotation per stage.
// Returns atan(ratio / 2^30) in Q16 degrees.
// ----------------------------------------------------------------------------
module lac_cordic #(
  parameter int unsigned TW = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                en,
  input  wire logic                                v_in,
  input  wire logic [lac_pkg::RATIO_W-1:0]         ratio,
  input  wire logic [TW-1:0]                       tag_in,
  output logic                                     v_out,
  output logic signed [lac_pkg::ANG_W-1:0]         ang,
  output logic [TW-1:0]                            tag_out
);

  localparam int unsigned N  = lac_pkg::CORDIC_STEPS;
  localparam int unsigned XW = lac_pkg::CX_W;
  localparam int unsigned AW = lac_pkg::ANG_W;

  logic [XW-1:0]        x_r   [N];
  logic [XW-1:0]        y_r   [N];
  logic                 yn_r  [N];
  logic signed [AW-1:0] a_r   [N];
  logic [TW-1:0]        tag_r [N];
  logic [N-1:0]         v_r;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [XW-1:0]        x_s, y_s, xs, ys, x_nxt, y_nxt;
    logic                 yn_s, yn_nxt;
    logic signed [AW-1:0] a_s, a_nxt;
    logic [TW-1:0]        tag_s;
    logic                 v_s;

    if (k == 0) begin : g_first
      assign x_s   = XW'(1) << 30;
      assign y_s   = XW'(ratio);
      assign yn_s  = 1'b0;
      assign a_s   = '0;
      assign tag_s = tag_in;
      assign v_s   = v_in;
    end else begin : g_rest
      assign x_s   = x_r[k-1];
      assign y_s   = y_r[k-1];
      assign yn_s  = yn_r[k-1];
      assign a_s   = a_r[k-1];
      assign tag_s = tag_r[k-1];
      assign v_s   = v_r[k-1];
    end

    always_comb begin
      xs    = x_s >> k;
      ys    = y_s >> k;
      x_nxt = x_s + ys;
      a_nxt = yn_s ? a_s - lac_pkg::atan_tab(k) : a_s + lac_pkg::atan_tab(k);
      // y is kept as a magnitude with a separate sign
      if (xs > y_s) begin
        y_nxt  = xs - y_s;
        yn_nxt = !yn_s;
      end else begin
        y_nxt  = y_s - xs;
        yn_nxt = yn_s;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_s;
      end
      if (en) begin
        x_r[k]   <= x_nxt;
        y_r[k]   <= y_nxt;
        yn_r[k]  <= yn_nxt;
        a_r[k]   <= a_nxt;
        tag_r[k] <= tag_s;
      end
    end
  end

  assign v_out   = v_r[N-1];
  assign ang     = a_r[N-1];
  assign tag_out = tag_r[N-1];

endmodule
`default_nettype wire
